@@ sv/bpc_pkg.sv @@
// shared types and constants for the barometric pressure and temperature compensation block
// no dependencies; imported by every module of the block
package bpc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_SENS       = 3'd0;
	localparam logic [2:0] REG_OFFSET     = 3'd1;
	localparam logic [2:0] REG_SENS_TEMP  = 3'd2;
	localparam logic [2:0] REG_OFF_TEMP   = 3'd3;
	localparam logic [2:0] REG_REF_TEMP   = 3'd4;
	localparam logic [2:0] REG_TEMP_SLOPE = 3'd5;
	localparam logic [2:0] REG_SO_ENABLE  = 3'd6;

	// temperature thresholds in hundredths of a degree
	localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
	localparam logic signed [18:0] TEMP_VLOW = -19'sd1500;
	localparam logic signed [19:0] TEMP_REF_W  = 20'sd2000;
	localparam logic signed [19:0] TEMP_VLOW_W = 20'sd1500;

	// cycles from an accepted start to the done strobe
	localparam int unsigned LATENCY = 10;

	// input word
	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} bpc_in_t;

	// result word
	typedef struct packed {
		logic signed [15:0] temperature;
		logic [17:0]        pressure;
	} bpc_out_t;

	// calibration set
	typedef struct packed {
		logic [15:0] sens_coeff;
		logic [15:0] offset_coeff;
		logic [15:0] sens_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] ref_temp_coeff;
		logic [15:0] temp_slope_coeff;
		logic        second_order_enable;
	} bpc_cfg_t;

	// calibration after reset: all words zero, second order on
	localparam bpc_cfg_t CFG_RESET = '{
		sens_coeff:          16'd0,
		offset_coeff:        16'd0,
		sens_temp_coeff:     16'd0,
		offset_temp_coeff:   16'd0,
		ref_temp_coeff:      16'd0,
		temp_slope_coeff:    16'd0,
		second_order_enable: 1'b1
	};

	// hand-off from the compensation front end to the pressure back end
	typedef struct packed {
		logic               valid;
		logic [23:0]        d1;
		logic signed [19:0] temp;
		logic signed [43:0] off;
		logic signed [39:0] sens;
	} bpc_mid_t;

endpackage

@@ sv/bpc_cfg.sv @@
// calibration register file with a plain write port
// depends on bpc_pkg
module bpc_cfg import bpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [15:0] cfg_wdata,
	output bpc_cfg_t  cfg
);

	bpc_cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SENS:       cfg_q.sens_coeff          <= cfg_wdata;
				REG_OFFSET:     cfg_q.offset_coeff        <= cfg_wdata;
				REG_SENS_TEMP:  cfg_q.sens_temp_coeff     <= cfg_wdata;
				REG_OFF_TEMP:   cfg_q.offset_temp_coeff   <= cfg_wdata;
				REG_REF_TEMP:   cfg_q.ref_temp_coeff      <= cfg_wdata;
				REG_TEMP_SLOPE: cfg_q.temp_slope_coeff    <= cfg_wdata;
				REG_SO_ENABLE:  cfg_q.second_order_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/bpc_comp.sv @@
// front end: temperature difference, first and second order temperature, offset and sensitivity
// six pipeline stages; depends on bpc_pkg
module bpc_comp import bpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  bpc_in_t   in_word,
	input  bpc_cfg_t  cfg,
	output bpc_mid_t  mid
);

	// valid chain
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stage 1: temperature difference
	logic [23:0]        d1_s1;
	logic signed [24:0] dt_s1;

	always_ff @(posedge clk) begin
		d1_s1 <= in_word.raw_pressure;
		dt_s1 <= $signed({1'b0, in_word.raw_temperature})
			- $signed({1'b0, cfg.ref_temp_coeff, 8'b0});
	end

	// stage 2: products of the temperature difference
	logic [23:0]        d1_s2;
	logic signed [41:0] p6_s2, p4_s2, p3_s2;
	logic [47:0]        dtsq_s2;
	logic signed [49:0] dtsq;

	assign dtsq = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		d1_s2   <= d1_s1;
		p6_s2   <= dt_s1 * $signed({1'b0, cfg.temp_slope_coeff});
		p4_s2   <= dt_s1 * $signed({1'b0, cfg.offset_temp_coeff});
		p3_s2   <= dt_s1 * $signed({1'b0, cfg.sens_temp_coeff});
		dtsq_s2 <= dtsq[47:0];
	end

	// stage 3: scaled terms, divisions truncate toward zero
	logic signed [41:0] q6, q4, q3;
	logic [49:0]        m3;
	logic [50:0]        m5;
	logic [23:0]        d1_s3;
	logic signed [18:0] temp1_s3;
	logic signed [36:0] off1_s3;
	logic signed [35:0] sens1_s3;
	logic [16:0]        t2lo_s3;
	logic [12:0]        t2hi_s3;

	assign q6 = (p6_s2 + $signed({19'b0, {23{p6_s2[41]}}})) >>> 23;
	assign q4 = (p4_s2 + $signed({36'b0, {6{p4_s2[41]}}})) >>> 6;
	assign q3 = (p3_s2 + $signed({35'b0, {7{p3_s2[41]}}})) >>> 7;
	assign m3 = {2'b0, dtsq_s2} + {1'b0, dtsq_s2, 1'b0};
	assign m5 = {3'b0, dtsq_s2} + {1'b0, dtsq_s2, 2'b0};

	always_ff @(posedge clk) begin
		d1_s3    <= d1_s2;
		temp1_s3 <= TEMP_REF + $signed(q6[18:0]);
		off1_s3  <= $signed({4'b0, cfg.offset_coeff, 17'b0}) + $signed(q4[36:0]);
		sens1_s3 <= $signed({4'b0, cfg.sens_coeff, 16'b0}) + $signed(q3[35:0]);
		t2lo_s3  <= m3[49:33];
		t2hi_s3  <= m5[50:38];
	end

	// stage 4: temperature band, squares and corrected temperature
	logic signed [19:0] temp1_w, a, b;
	logic signed [39:0] asq_full, bsq_full;
	logic               lt_ref, lt_vlow;
	logic [16:0]        t2;
	logic [23:0]        d1_s4;
	logic signed [19:0] temp2_s4;
	logic signed [36:0] off1_s4;
	logic signed [35:0] sens1_s4;
	logic [33:0]        asq_s4;
	logic [34:0]        bsq_s4;
	logic               corr_lo_s4, corr_vlo_s4;

	assign temp1_w  = {temp1_s3[18], temp1_s3};
	assign a        = temp1_w - TEMP_REF_W;
	assign b        = temp1_w + TEMP_VLOW_W;
	assign asq_full = a * a;
	assign bsq_full = b * b;
	assign lt_ref   = temp1_s3 < TEMP_REF;
	assign lt_vlow  = temp1_s3 < TEMP_VLOW;

	// temperature correction pick
	always_comb begin
		t2 = '0;
		if (cfg.second_order_enable) begin
			if (lt_ref) t2 = t2lo_s3;
			else        t2 = {4'b0, t2hi_s3};
		end
	end

	always_ff @(posedge clk) begin
		d1_s4       <= d1_s3;
		temp2_s4    <= temp1_w - $signed({3'b0, t2});
		off1_s4     <= off1_s3;
		sens1_s4    <= sens1_s3;
		asq_s4      <= asq_full[33:0];
		bsq_s4      <= bsq_full[34:0];
		corr_lo_s4  <= cfg.second_order_enable & lt_ref;
		corr_vlo_s4 <= cfg.second_order_enable & lt_ref & lt_vlow;
	end

	// stage 5: offset and sensitivity corrections
	logic [39:0]        a61, a29, b17, b9;
	logic [35:0]        off2_lo, sens2_lo;
	logic [39:0]        off2_vlo, sens2_vlo;
	logic [23:0]        d1_s5;
	logic signed [19:0] temp2_s5;
	logic signed [36:0] off1_s5;
	logic signed [35:0] sens1_s5;
	logic [40:0]        off2_s5, sens2_s5;

	assign a61       = {6'b0, asq_s4} * 40'd61;
	assign a29       = {6'b0, asq_s4} * 40'd29;
	assign b17       = {5'b0, bsq_s4} * 40'd17;
	assign b9        = {5'b0, bsq_s4} * 40'd9;
	assign off2_lo   = corr_lo_s4  ? a61[39:4] : '0;
	assign sens2_lo  = corr_lo_s4  ? a29[39:4] : '0;
	assign off2_vlo  = corr_vlo_s4 ? b17 : '0;
	assign sens2_vlo = corr_vlo_s4 ? b9  : '0;

	always_ff @(posedge clk) begin
		d1_s5    <= d1_s4;
		temp2_s5 <= temp2_s4;
		off1_s5  <= off1_s4;
		sens1_s5 <= sens1_s4;
		off2_s5  <= {5'b0, off2_lo} + {1'b0, off2_vlo};
		sens2_s5 <= {5'b0, sens2_lo} + {1'b0, sens2_vlo};
	end

	// stage 6: corrected offset and sensitivity
	logic signed [41:0] sens_d;
	logic [23:0]        d1_s6;
	logic signed [19:0] temp_s6;
	logic signed [43:0] off_s6;
	logic signed [39:0] sens_s6;

	assign sens_d = $signed({{6{sens1_s5[35]}}, sens1_s5}) - $signed({1'b0, sens2_s5});

	always_ff @(posedge clk) begin
		d1_s6   <= d1_s5;
		temp_s6 <= temp2_s5;
		off_s6  <= $signed({{7{off1_s5[36]}}, off1_s5}) - $signed({3'b0, off2_s5});
		sens_s6 <= sens_d[39:0];
	end

	assign mid.valid = valid_s6;
	assign mid.d1    = d1_s6;
	assign mid.temp  = temp_s6;
	assign mid.off   = off_s6;
	assign mid.sens  = sens_s6;

endmodule

@@ sv/bpc_pres.sv @@
// back end: pressure product in two partial products, scaling and output saturation
// four pipeline stages; depends on bpc_pkg
module bpc_pres import bpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  bpc_mid_t mid,
	output logic     done,
	output bpc_out_t result
);

	// valid chain
	logic valid_s7, valid_s8, valid_s9, valid_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			valid_s7  <= mid.valid;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// stage 7: raw pressure times low and high halves of sensitivity
	logic [43:0]        pplo_s7;
	logic signed [44:0] pphi_s7;
	logic signed [43:0] off_s7;
	logic signed [19:0] temp_s7;

	always_ff @(posedge clk) begin
		pplo_s7 <= mid.d1 * mid.sens[19:0];
		pphi_s7 <= $signed({1'b0, mid.d1}) * $signed(mid.sens[39:20]);
		off_s7  <= mid.off;
		temp_s7 <= mid.temp;
	end

	// stage 8: recombine the partial products
	logic signed [63:0] prod_s8;
	logic signed [43:0] off_s8;
	logic signed [19:0] temp_s8;

	always_ff @(posedge clk) begin
		prod_s8 <= $signed({pphi_s7[43:0], 20'b0} + {20'b0, pplo_s7});
		off_s8  <= off_s7;
		temp_s8 <= temp_s7;
	end

	// stage 9: scale down and remove the offset
	logic signed [63:0] pq21;
	logic signed [44:0] q_s9;
	logic signed [19:0] temp_s9;

	assign pq21 = (prod_s8 + $signed({43'b0, {21{prod_s8[63]}}})) >>> 21;

	always_ff @(posedge clk) begin
		q_s9    <= $signed(pq21[44:0]) - $signed({off_s8[43], off_s8});
		temp_s9 <= temp_s8;
	end

	// stage 10: final scaling and saturation of both results
	logic signed [44:0] pq15;
	logic [17:0]        pres_sat;
	logic signed [15:0] temp_sat;
	bpc_out_t           result_s10;

	assign pq15 = (q_s9 + $signed({30'b0, {15{q_s9[44]}}})) >>> 15;

	always_comb begin
		if (pq15[44])              pres_sat = '0;
		else if (|pq15[43:18])     pres_sat = '1;
		else                       pres_sat = pq15[17:0];
		if (temp_s9[19] && !(&temp_s9[18:15]))      temp_sat = 16'sh8000;
		else if (!temp_s9[19] && (|temp_s9[18:15])) temp_sat = 16'sh7FFF;
		else                                        temp_sat = temp_s9[15:0];
	end

	always_ff @(posedge clk) begin
		result_s10.temperature <= temp_sat;
		result_s10.pressure    <= pres_sat;
	end

	assign done   = valid_s10;
	assign result = result_s10;

endmodule

@@ sv/baro_pressure_temp_compensation.sv @@
// each taken start gives a done strobe at the end of the pipeline; throughput one word per cycle
// ten register stages (six in the front end, four in the pressure back end) set the latency
// busy stays low, so start is taken in every cycle; each result shows for one cycle only
// reset: arst_n clears the valid chain and loads calibration to zero with second order on
// depends on bpc_pkg, bpc_cfg, bpc_comp and bpc_pres
module baro_pressure_temp_compensation import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  bpc_in_t     item,
	output logic        done,
	output bpc_out_t    result
);

	bpc_cfg_t cfg;
	bpc_mid_t mid;

	// pipeline never holds off a word
	assign busy = 1'b0;

	// calibration registers
	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// temperature, offset and sensitivity
	bpc_comp u_comp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.in_word  (item),
		.cfg      (cfg),
		.mid      (mid)
	);

	// pressure and saturation
	bpc_pres u_pres (
		.clk    (clk),
		.arst_n (arst_n),
		.mid    (mid),
		.done   (done),
		.result (result)
	);

endmodule

@@ sv/bpc_checker.sv @@
// port-level checks for the compensation block, attached by bind
// depends on bpc_pkg and the top level baro_pressure_temp_compensation
module bpc_checker import bpc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input bpc_out_t    result
);

	// every taken word gives a strobe after the pipeline latency
	a_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("taken word produced no result");

	// no strobe without a word taken the latency before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching word");

	// no strobe shortly after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done)
		else $error("result strobe right after reset");

	// the block never stalls the sender
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// a strobed word carries known data
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("unknown bits in a strobed result");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (.*);

@@ tb/baro_pressure_temp_compensation_tb.sv @@
// self-checking testbench for baro_pressure_temp_compensation: directed words, then random phases
// predicts every result from its own calibration copy; depends on bpc_pkg and the block's rtl
module baro_pressure_temp_compensation_tb;
	import bpc_pkg::*;

	// index with no register behind it
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int QUIET_LIMIT = 1000;
	localparam int REPORT_LIMIT = 10;

	// power of two divisors of the compensation formulas
	localparam longint POW2_6  = 64'sd1 << 6;
	localparam longint POW2_7  = 64'sd1 << 7;
	localparam longint POW2_15 = 64'sd1 << 15;
	localparam longint POW2_16 = 64'sd1 << 16;
	localparam longint POW2_17 = 64'sd1 << 17;
	localparam longint POW2_21 = 64'sd1 << 21;
	localparam longint POW2_23 = 64'sd1 << 23;
	localparam longint POW2_33 = 64'sd1 << 33;
	localparam longint POW2_38 = 64'sd1 << 38;

	// typical calibration set
	localparam logic [15:0] TYP_C1 = 16'd46372;
	localparam logic [15:0] TYP_C2 = 16'd43981;
	localparam logic [15:0] TYP_C3 = 16'd29059;
	localparam logic [15:0] TYP_C4 = 16'd27842;
	localparam logic [15:0] TYP_C5 = 16'd31553;
	localparam logic [15:0] TYP_C6 = 16'd28165;
	localparam logic [23:0] TYP_D1 = 24'd6465444;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;
	logic        start = 1'b0;
	logic        busy;
	bpc_in_t     item = '0;
	logic        done;
	bpc_out_t    result;

	bpc_in_t  pending_words[$];
	bpc_out_t expected_readings[$];
	bpc_cfg_t cal_copy = {96'd0, 1'b1};
	logic     word_taken = 1'b0;
	int       gap_odds = 0;
	int       gap_left = 0;
	int       mismatch_count = 0;
	int       quiet_cycles = 0;

	baro_pressure_temp_compensation uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	// clock, period 4
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// compensated temperature and pressure for one raw pair
	function automatic bpc_out_t compensate_sample(bpc_in_t w, bpc_cfg_t c);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, tc, off, sens, t2, off2, sens2, a, b, pres;
		bpc_out_t r;
		d1 = w.raw_pressure;
		d2 = w.raw_temperature;
		c1 = c.sens_coeff;
		c2 = c.offset_coeff;
		c3 = c.sens_temp_coeff;
		c4 = c.offset_temp_coeff;
		c5 = c.ref_temp_coeff;
		c6 = c.temp_slope_coeff;
		dt = d2 - c5 * 256;
		tc = 2000 + dt * c6 / POW2_23;
		off = c2 * POW2_17 + dt * c4 / POW2_6;
		sens = c1 * POW2_16 + dt * c3 / POW2_7;
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		// second order terms, decided on the first order temperature
		if (c.second_order_enable) begin
			if (tc < 2000) begin
				a = tc - 2000;
				t2 = 3 * (dt * dt) / POW2_33;
				off2 = 61 * a * a / 16;
				sens2 = 29 * a * a / 16;
				if (tc < -1500) begin
					b = tc + 1500;
					off2 += 17 * b * b;
					sens2 += 9 * b * b;
				end
			end else begin
				t2 = 5 * (dt * dt) / POW2_38;
			end
		end
		tc -= t2;
		off -= off2;
		sens -= sens2;
		pres = (d1 * sens / POW2_21 - off) / POW2_15;
		// saturation
		if (tc < -32768) tc = -32768;
		if (tc > 32767) tc = 32767;
		if (pres < 0) pres = 0;
		if (pres > 262143) pres = 262143;
		r.temperature = tc[15:0];
		r.pressure = pres[17:0];
		return r;
	endfunction

	// coefficient near a typical value
	function automatic logic [15:0] jitter_coeff(int base);
		int v;
		v = base + $urandom_range(0, 4000) - 2000;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return v[15:0];
	endfunction

	// coefficient drawn from the extremes or anywhere
	function automatic logic [15:0] wild_coeff();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_cal(input logic [15:0] c1, c2, c3, c4, c5, c6, input logic en);
		logic [14:0] junk;
		junk = 15'($urandom);
		write_reg(REG_SENS, c1);
		write_reg(REG_OFFSET, c2);
		write_reg(REG_SENS_TEMP, c3);
		write_reg(REG_OFF_TEMP, c4);
		write_reg(REG_REF_TEMP, c5);
		write_reg(REG_TEMP_SLOPE, c6);
		// upper bits of the enable write are don't care
		write_reg(REG_SO_ENABLE, {junk, en});
	endtask

	task automatic queue_word(input logic [23:0] p, input logic [23:0] t);
		pending_words.push_back({p, t});
	endtask

	// wait until every queued word is taken and every result is back
	task automatic drain();
		@(posedge clk);
		while (pending_words.size() != 0 || start) @(posedge clk);
		while (expected_readings.size() != 0) @(negedge clk);
	endtask

	// driver: one word per start, random idle bursts
	always @(negedge clk) begin
		if (start && !word_taken) begin
			// hold the word until taken
		end else if (gap_left != 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (pending_words.size() == 0) begin
			start <= 1'b0;
		end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			gap_left = $urandom_range(1, 17) - 1;
			start <= 1'b0;
		end else begin
			item <= pending_words.pop_front();
			start <= 1'b1;
		end
	end

	// monitor: check results, predict taken words, track calibration writes
	always @(posedge clk) begin
		bpc_out_t want;
		if (done) begin
			if (expected_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: temperature %0d pressure %0d",
						result.temperature, result.pressure);
			end else begin
				want = expected_readings.pop_front();
				if (result.temperature !== want.temperature || result.pressure !== want.pressure) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: expected temperature %0d pressure %0d, got %0d %0d",
							want.temperature, want.pressure, result.temperature, result.pressure);
				end
			end
		end
		if (arst_n && start && !busy)
			expected_readings.push_back(compensate_sample(item, cal_copy));
		if (arst_n && cfg_we) begin
			case (cfg_addr)
				REG_SENS:       cal_copy.sens_coeff = cfg_wdata;
				REG_OFFSET:     cal_copy.offset_coeff = cfg_wdata;
				REG_SENS_TEMP:  cal_copy.sens_temp_coeff = cfg_wdata;
				REG_OFF_TEMP:   cal_copy.offset_temp_coeff = cfg_wdata;
				REG_REF_TEMP:   cal_copy.ref_temp_coeff = cfg_wdata;
				REG_TEMP_SLOPE: cal_copy.temp_slope_coeff = cfg_wdata;
				REG_SO_ENABLE:  cal_copy.second_order_enable = cfg_wdata[0];
				default: ;
			endcase
		end
		word_taken <= arst_n && start && !busy;
	end

	// watchdog on cycles with no word taken and no result
	always @(posedge clk) begin
		if (done || (start && !busy))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL baro_pressure_temp_compensation");
			$finish;
		end
	end

	// stimulus
	initial begin
		int i, k, n, centre, d1v, d2v;
		logic [15:0] c1, c2, c3, c4, c5, c6;
		logic en;
		bit wild;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		gap_odds = 6;

		// reset calibration, second order on by default
		@(posedge clk);
		queue_word(24'h000000, 24'h000000);
		queue_word(24'hFFFFFF, 24'hFFFFFF);
		drain();

		// write to an index with no register is dropped
		write_reg(REG_UNUSED, 16'hFFFF);
		@(posedge clk);
		queue_word(24'hFFFFFF, 24'h800000);
		drain();

		// typical calibration: high, low and very low temperature, pressure extremes
		program_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 1'b1);
		@(posedge clk);
		queue_word(TYP_D1, 24'd9000000);
		queue_word(TYP_D1, 24'd7500000);
		queue_word(TYP_D1, 24'd6000000);
		queue_word(24'h000000, 24'd8077636);
		queue_word(24'hFFFFFF, 24'd8077636);
		drain();

		// thresholds at 20 and -15 degrees, truncation toward zero just below 20
		program_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, 16'd32768, 16'd32768, 1'b1);
		@(posedge clk);
		queue_word(TYP_D1, 24'd8388353);
		queue_word(TYP_D1, 24'd8388352);
		queue_word(TYP_D1, 24'd7492608);
		queue_word(TYP_D1, 24'd7492352);
		drain();

		// second order off
		program_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, 16'd32768, 16'd32768, 1'b0);
		@(posedge clk);
		queue_word(TYP_D1, 24'd7492352);
		queue_word(TYP_D1, 24'd10388608);
		drain();

		// saturation high
		program_cal(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
		@(posedge clk);
		queue_word(24'hFFFFFF, 24'hFFFFFF);
		queue_word(24'h000000, 24'hFFFFFF);
		drain();

		// saturation low
		program_cal(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		@(posedge clk);
		queue_word(24'hFFFFFF, 24'h000000);
		queue_word(24'h000000, 24'hFFFFFF);
		drain();
		program_cal(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		@(posedge clk);
		queue_word(24'hFFFFFF, 24'h000000);
		drain();

		// random phases, typical or wild calibration, last ones without idling
		for (i = 0; i < 12; i++) begin
			wild = (i % 3 == 2);
			en = (i % 2 == 0);
			if (wild) begin
				c1 = wild_coeff();
				c2 = wild_coeff();
				c3 = wild_coeff();
				c4 = wild_coeff();
				c5 = wild_coeff();
				c6 = wild_coeff();
			end else begin
				c1 = jitter_coeff(int'(TYP_C1));
				c2 = jitter_coeff(int'(TYP_C2));
				c3 = jitter_coeff(int'(TYP_C3));
				c4 = jitter_coeff(int'(TYP_C4));
				c5 = jitter_coeff(int'(TYP_C5));
				c6 = jitter_coeff(int'(TYP_C6));
			end
			program_cal(c1, c2, c3, c4, c5, c6, en);
			gap_odds = (i < 10) ? $urandom_range(3, 12) : 0;
			n = $urandom_range(120, 180);
			@(posedge clk);
			for (k = 0; k < n; k++) begin
				case ($urandom_range(0, 7))
					0: d1v = 0;
					1: d1v = 24'hFFFFFF;
					2, 3: d1v = $urandom_range(0, 24'hFFFFFF);
					default: d1v = int'(TYP_D1) + $urandom_range(0, 4000000) - 2000000;
				endcase
				// raw temperature mostly around the reference point
				case ($urandom_range(0, 7))
					0: d2v = $urandom_range(0, 24'hFFFFFF);
					1: d2v = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
					default: begin
						centre = int'(c5) * 256;
						d2v = centre + $urandom_range(0, 6000000) - 3000000;
						if (d2v < 0) d2v = 0;
						if (d2v > 24'hFFFFFF) d2v = 24'hFFFFFF;
					end
				endcase
				queue_word(d1v[23:0], d2v[23:0]);
			end
			drain();
		end

		repeat (LATENCY + 4) @(posedge clk);
		if (expected_readings.size() != 0) begin
			mismatch_count += expected_readings.size();
			$display("%0d expected results never arrived", expected_readings.size());
		end
		if (mismatch_count == 0)
			$display("PASS baro_pressure_temp_compensation");
		else
			$display("FAIL baro_pressure_temp_compensation");
		$finish;
	end

endmodule

@@ files.f @@
sv/bpc_pkg.sv
sv/bpc_cfg.sv
sv/bpc_comp.sv
sv/bpc_pres.sv
sv/baro_pressure_temp_compensation.sv
sv/bpc_checker.sv
tb/baro_pressure_temp_compensation_tb.sv
